// ===== rtl/hq_pkg.sv =====
// Deadline heap timer queue: shared constants, codes and types.
// No dependencies; compiled first.
`default_nettype none

package hq_pkg;

    localparam int SLOTS   = 32;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int TIME_W  = 64;
    localparam int SEQ_W   = 32;
    localparam int AMT_W   = 16;
    localparam int QUANT_W = 10;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 3;
    localparam int HSLOT_W = 6;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [SEQ_W-1:0]   SEQ_RESET   = 32'h1234ABCD;
    localparam logic [QUANT_W-1:0] QUANT_RESET = 10'd50;
    localparam logic [AMT_W-1:0]   MAXD_RESET  = 16'd60000;
    localparam logic [CNT_W-1:0]   MAX_OUT     = CNT_W'(32);

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_ADVANCE = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ISSUED  = 3'd0,
        KIND_CANCEL  = 3'd1,
        KIND_EXPIRED = 3'd2,
        KIND_FULL    = 3'd3,
        KIND_NONE    = 3'd4
    } t_kind;

    // register index = paddr[2]
    localparam logic REG_QUANTUM  = 1'b0;
    localparam logic REG_MAXDELAY = 1'b1;

    typedef struct packed {
        logic [QUANT_W-1:0] quantum;
        logic [AMT_W-1:0]   max_delay;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_RQ_ALLOC, S_RQ_INS, S_FULL,
        S_SU_CHK, S_SU_R1, S_SU_R2,
        S_CN_CHK, S_RM_START, S_RM_R1, S_RM_R2,
        S_SD_CHK, S_SD_R1, S_SD_R2, S_SD_R3, S_SD_R4, S_SD_R5, S_SD_CMP,
        S_AD_TOP, S_AD_R1, S_AD_R2, S_AD_PUSH, S_AD_END,
        S_RQ_FIN, S_RQ_EMIT, S_CN_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/hq_in_if.sv =====
// Input channel of the timer queue: valid/ready plus one command.
// Depends on hq_pkg.
`default_nettype none

interface hq_in_if;
    import hq_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [AMT_W-1:0]    amount_ms;
    logic [HSLOT_W-1:0]  handle_slot;
    logic [SEQ_W-1:0]    handle_seq;
    modport source (output valid, op, amount_ms, handle_slot, handle_seq, input ready);
    modport sink   (input valid, op, amount_ms, handle_slot, handle_seq, output ready);
endinterface

`default_nettype wire

// ===== rtl/hq_out_if.sv =====
// Output channel of the timer queue: valid/ready plus one result.
// Depends on hq_pkg.
`default_nettype none

interface hq_out_if;
    import hq_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HSLOT_W-1:0]  token_slot;
    logic [SEQ_W-1:0]    token_seq;
    logic                last;
    modport source (output valid, kind, token_slot, token_seq, last, input ready);
    modport sink   (input valid, kind, token_slot, token_seq, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/hq_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module hq_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== rtl/hq_div.sv =====
// Bit-serial restoring divider: 64-bit dividend by 10-bit divisor.
// Depends on hq_pkg. One quotient bit per cycle.
`default_nettype none

module hq_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [hq_pkg::TIME_W-1:0]    i_num,
    input  wire logic [hq_pkg::QUANT_W-1:0]   i_den,
    output logic                              o_done,
    output logic      [hq_pkg::TIME_W-1:0]    o_quo
);
    import hq_pkg::*;

    localparam int CW = $clog2(TIME_W) + 1;

    logic [QUANT_W-1:0] r_den;
    logic [QUANT_W-1:0] r_rem;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic [QUANT_W:0]   rem_sh;
    logic               ge;

    assign rem_sh = {r_rem, o_quo[TIME_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                o_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= ge ? QUANT_W'(rem_sh - {1'b0, r_den}) : rem_sh[QUANT_W-1:0];
                o_quo <= {o_quo[TIME_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

`default_nettype wire

// ===== rtl/hq_cfg.sv =====
// APB-style register file: quantum and maximum delay.
// Depends on hq_pkg.
`default_nettype none

module hq_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [hq_pkg::PDATA_W-1:0]  pwdata,
    output logic      [hq_pkg::PDATA_W-1:0]  prdata,
    output logic                             pready,
    output hq_pkg::t_cfg                     o_cfg
);
    import hq_pkg::*;

    t_cfg r_cfg;

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quantum   <= QUANT_RESET;
            r_cfg.max_delay <= MAXD_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_QUANTUM:  r_cfg.quantum   <= pwdata[QUANT_W-1:0];
                REG_MAXDELAY: r_cfg.max_delay <= pwdata[AMT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_QUANTUM:  prdata = PDATA_W'(r_cfg.quantum);
            REG_MAXDELAY: prdata = PDATA_W'(r_cfg.max_delay);
            default:      prdata = '0;
        endcase
    end
endmodule

`default_nettype wire

// ===== rtl/deadline_heap_timer_queue.sv =====
// Top level of the deadline timer queue: heap sequencer, heap and deadline RAMs.
// Depends on hq_pkg, hq_in_if, hq_out_if, hq_ram, hq_div, hq_cfg.
`default_nettype none

// Timer queue kept as a binary min-heap of slots ordered by quantized deadline.
// i_in carries commands (request, cancel, advance); o_out carries result
// transfers, the final one of each command marked with last. Commands are taken
// one at a time: i_in.ready is high only while the sequencer is idle.
// Steps per command:
//   request: a serial divide (one quotient bit per cycle), a climb up the
//            heap for the new timer, then the cancel of the old token (a
//            removal: a sift down, then a climb up).
//   cancel:  a check of the token plus the removal.
//   advance: a divide, then per expired timer a read of the heap top plus
//            its removal; at most 32 expirations per advance.
// The divider and the single read port of each RAM set the pace of each step.
// Results sit in an output register; a stalled receiver holds the sequencer
// in its next emitting state, nothing is lost. Expirations are held one deep
// so that last can be set on the final one.
// Reset (synchronous, active low) empties the heap, the free list and the
// slot count, clears time and marks every sequence at its reset value; no
// clearing pass is needed. Users must write config registers only while idle; not enforced.
module deadline_heap_timer_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    hq_in_if.sink                            i_in,
    hq_out_if.source                         o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [hq_pkg::PDATA_W-1:0]  pwdata,
    output logic      [hq_pkg::PDATA_W-1:0]  prdata,
    output logic                             pready
);
    import hq_pkg::*;

    t_cfg cfg;

    hq_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    t_state r_state, n_state;

    // latched command
    logic [OP_W-1:0]    r_op;
    logic [HSLOT_W-1:0] r_hslot;
    logic [SEQ_W-1:0]   r_hseq;

    // queue state
    logic [TIME_W-1:0]  r_now;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_made;
    logic [CNT_W-1:0]   r_fcnt;
    logic [SEQ_W-1:0]   r_seq  [SLOTS];
    logic [SLOTS-1:0]   r_seqv;
    logic [SLOT_W-1:0]  r_posa [SLOTS];
    logic [SLOTS-1:0]   r_inh;
    logic [SLOT_W-1:0]  r_fs   [SLOTS];

    // working registers
    logic [SLOT_W-1:0]  r_slot, r_nslot, r_sslot, r_pos, r_c, r_cs, r_rs;
    logic [TIME_W-1:0]  r_d, r_dcs, r_nowq;
    logic               r_ins, r_hit;
    logic [CNT_W-1:0]   r_n;
    logic               r_pend_v;
    logic [HSLOT_W-1:0] r_pend_slot;
    logic [SEQ_W-1:0]   r_pend_seq;

    // output register
    logic               r_out_v;
    logic [KIND_W-1:0]  r_out_kind;
    logic [HSLOT_W-1:0] r_out_slot;
    logic [SEQ_W-1:0]   r_out_seq;
    logic               r_out_last;

    // RAM ports
    logic               heap_we, dl_we;
    logic [SLOT_W-1:0]  heap_wa, heap_wd, heap_ra, heap_rd;
    logic [SLOT_W-1:0]  dl_wa, dl_ra;
    logic [TIME_W-1:0]  dl_wd, dl_rd;

    hq_ram #(.W(SLOT_W), .D(SLOTS)) u_heap (
        .i_clk, .i_we(heap_we), .i_waddr(heap_wa), .i_wdata(heap_wd),
        .i_raddr(heap_ra), .o_rdata(heap_rd)
    );

    hq_ram #(.W(TIME_W), .D(SLOTS)) u_dl (
        .i_clk, .i_we(dl_we), .i_waddr(dl_wa), .i_wdata(dl_wd),
        .i_raddr(dl_ra), .o_rdata(dl_rd)
    );

    // divider
    logic               div_start, div_done;
    logic [TIME_W-1:0]  div_num, div_quo;
    logic [QUANT_W-1:0] eff_q;
    logic [AMT_W-1:0]   delay;
    logic               in_fire;

    assign eff_q   = (cfg.quantum == '0) ? QUANT_W'(1) : cfg.quantum;
    assign delay   = (i_in.amount_ms > cfg.max_delay) ? cfg.max_delay : i_in.amount_ms;
    assign in_fire = i_in.valid && i_in.ready;
    assign div_start = in_fire && (i_in.op == OP_REQUEST || i_in.op == OP_ADVANCE);
    assign div_num = r_now + TIME_W'((i_in.op == OP_ADVANCE) ? i_in.amount_ms : delay);

    hq_div u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num), .i_den(eff_q),
        .o_done(div_done), .o_quo(div_quo)
    );

    // shared decode
    logic [SLOT_W-1:0]  seq_idx;
    logic [SEQ_W-1:0]   seq_val;
    logic [HSLOT_W-1:0] cn_idx;
    logic               cn_hit;
    logic               out_free;
    logic [SLOT_W-1:0]  su_parent;
    logic [CNT_W-1:0]   sd_c, c_next;
    logic               have_free, can_make;
    t_state             ret_state, after_cancel;

    assign cn_idx   = r_hslot - 1'b1;
    assign seq_idx  = (r_state == S_CN_CHK) ? cn_idx[SLOT_W-1:0] : r_slot;
    assign seq_val  = r_seqv[seq_idx] ? r_seq[seq_idx] : SEQ_RESET;
    assign cn_hit   = (r_hslot != '0) && (cn_idx < HSLOT_W'(r_made)) &&
                      (seq_val == r_hseq) && r_inh[cn_idx[SLOT_W-1:0]];
    assign out_free = !r_out_v || o_out.ready;
    assign su_parent = SLOT_W'((r_pos - 1'b1) >> 1);
    assign sd_c     = {r_pos, 1'b1};
    assign c_next   = CNT_W'(r_c) + 1'b1;
    assign have_free = r_fcnt != '0;
    assign can_make  = r_made < CNT_W'(SLOTS);

    assign after_cancel = (r_op == OP_REQUEST) ? S_RQ_FIN : S_CN_EMIT;
    always_comb begin
        if (r_ins) begin
            ret_state = S_CN_CHK;
        end else if (r_op == OP_ADVANCE) begin
            ret_state = S_AD_TOP;
        end else begin
            ret_state = after_cancel;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in.op)
                        OP_REQUEST, OP_ADVANCE: n_state = S_DIV;
                        OP_CANCEL:              n_state = S_CN_CHK;
                        default:                n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV:      if (div_done) n_state = (r_op == OP_ADVANCE) ? S_AD_TOP : S_RQ_ALLOC;
            S_RQ_ALLOC: n_state = (have_free || can_make) ? S_RQ_INS : S_FULL;
            S_RQ_INS:   n_state = S_SU_CHK;
            S_FULL:     if (out_free) n_state = S_IDLE;
            S_SU_CHK:   n_state = (r_pos == '0) ? ret_state : S_SU_R1;
            S_SU_R1:    n_state = S_SU_R2;
            S_SU_R2:    n_state = (dl_rd <= r_d) ? ret_state : S_SU_CHK;
            S_CN_CHK:   n_state = cn_hit ? S_RM_START : after_cancel;
            S_RM_START: n_state = (CNT_W'(r_pos) == r_count) ? ret_state : S_RM_R1;
            S_RM_R1:    n_state = S_RM_R2;
            S_RM_R2:    n_state = S_SD_CHK;
            S_SD_CHK:   n_state = (sd_c >= r_count) ? S_SU_CHK : S_SD_R1;
            S_SD_R1:    n_state = (c_next < r_count) ? S_SD_R2 : S_SD_R4;
            S_SD_R2:    n_state = S_SD_R3;
            S_SD_R3:    n_state = S_SD_R5;
            S_SD_R4:    n_state = S_SD_CMP;
            S_SD_R5:    n_state = S_SD_CMP;
            S_SD_CMP:   n_state = (r_d <= r_dcs) ? S_SU_CHK : S_SD_CHK;
            S_AD_TOP:   n_state = (r_n < MAX_OUT && r_count != '0) ? S_AD_R1 : S_AD_END;
            S_AD_R1:    n_state = S_AD_R2;
            S_AD_R2:    n_state = (dl_rd > r_nowq) ? S_AD_END : S_AD_PUSH;
            S_AD_PUSH:  if (!r_pend_v || out_free) n_state = S_RM_START;
            S_AD_END:   if (out_free) n_state = S_IDLE;
            S_RQ_FIN:   n_state = S_RQ_EMIT;
            S_RQ_EMIT:  if (out_free) n_state = S_IDLE;
            S_CN_EMIT:  if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // RAM controls and result pushes
    logic               push;
    logic [KIND_W-1:0]  push_kind;
    logic [HSLOT_W-1:0] push_slot;
    logic [SEQ_W-1:0]   push_seq;
    logic               push_last;

    always_comb begin
        heap_we = 1'b0; heap_wa = r_pos; heap_wd = r_sslot; heap_ra = '0;
        dl_we   = 1'b0; dl_wa   = r_sslot; dl_wd = r_d;     dl_ra   = r_cs;
        push = 1'b0; push_kind = KIND_NONE; push_slot = '0; push_seq = '0; push_last = 1'b1;
        unique case (r_state)
            S_RQ_INS: dl_we = 1'b1;
            S_FULL: begin
                push = out_free; push_kind = KIND_FULL;
            end
            S_SU_CHK: begin
                heap_ra = su_parent;
                heap_we = (r_pos == '0);
            end
            S_SU_R1: dl_ra = heap_rd;
            S_SU_R2: begin
                heap_we = 1'b1;
                heap_wd = (dl_rd <= r_d) ? r_sslot : r_cs;
            end
            S_RM_START: heap_ra = r_count[SLOT_W-1:0];
            S_RM_R1:    dl_ra = heap_rd;
            S_SD_CHK:   heap_ra = sd_c[SLOT_W-1:0];
            S_SD_R1: begin
                heap_ra = c_next[SLOT_W-1:0];
                dl_ra   = heap_rd;
            end
            S_SD_R2: dl_ra = r_cs;
            S_SD_R3: dl_ra = r_rs;
            S_SD_CMP: begin
                heap_we = !(r_d <= r_dcs);
                heap_wd = r_cs;
            end
            S_AD_TOP: heap_ra = '0;
            S_AD_R1:  dl_ra = heap_rd;
            S_AD_PUSH: begin
                push = r_pend_v && out_free; push_kind = KIND_EXPIRED;
                push_slot = r_pend_slot; push_seq = r_pend_seq; push_last = 1'b0;
            end
            S_AD_END: begin
                push = out_free;
                push_kind = r_pend_v ? KIND_EXPIRED : KIND_NONE;
                push_slot = r_pend_v ? r_pend_slot : '0;
                push_seq  = r_pend_v ? r_pend_seq : '0;
            end
            S_RQ_EMIT: begin
                push = out_free; push_kind = KIND_ISSUED;
                push_slot = HSLOT_W'(r_slot) + 1'b1; push_seq = seq_val;
            end
            S_CN_EMIT: begin
                push = out_free; push_kind = KIND_CANCEL;
                push_slot = r_hit ? r_hslot : '0;
                push_seq  = r_hit ? r_hseq : '0;
            end
            default: ;
        endcase
    end

    assign o_out.valid      = r_out_v;
    assign o_out.kind       = r_out_kind;
    assign o_out.token_slot = r_out_slot;
    assign o_out.token_seq  = r_out_seq;
    assign o_out.last       = r_out_last;

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_count  <= '0;
            r_made   <= '0;
            r_fcnt   <= '0;
            r_seqv   <= '0;
            r_inh    <= '0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_ins    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_out_v    <= 1'b1;
                r_out_kind <= push_kind;
                r_out_slot <= push_slot;
                r_out_seq  <= push_seq;
                r_out_last <= push_last;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op    <= i_in.op;
                        r_hslot <= i_in.handle_slot;
                        r_hseq  <= i_in.handle_seq;
                        r_ins   <= 1'b0;
                        if (i_in.op == OP_ADVANCE) r_now <= div_num;
                    end
                end
                S_DIV: begin
                    r_d      <= div_quo;
                    r_nowq   <= div_quo;
                    r_n      <= '0;
                    r_pend_v <= 1'b0;
                end
                S_RQ_ALLOC: begin
                    if (have_free) begin
                        r_nslot <= r_fs[r_fcnt[SLOT_W-1:0] - 1'b1];
                        r_sslot <= r_fs[r_fcnt[SLOT_W-1:0] - 1'b1];
                        r_slot  <= r_fs[r_fcnt[SLOT_W-1:0] - 1'b1];
                        r_fcnt  <= r_fcnt - 1'b1;
                    end else if (can_make) begin
                        r_nslot <= r_made[SLOT_W-1:0];
                        r_sslot <= r_made[SLOT_W-1:0];
                        r_slot  <= r_made[SLOT_W-1:0];
                        r_made  <= r_made + 1'b1;
                    end
                end
                S_RQ_INS: begin
                    r_seq[r_slot]  <= seq_val + 1'b1;
                    r_seqv[r_slot] <= 1'b1;
                    r_inh[r_slot]  <= 1'b1;
                    r_count        <= r_count + 1'b1;
                    r_pos          <= r_count[SLOT_W-1:0];
                    r_ins          <= 1'b1;
                end
                S_SU_CHK: if (r_pos == '0) r_posa[r_sslot] <= '0;
                S_SU_R1:  r_cs <= heap_rd;
                S_SU_R2: begin
                    if (dl_rd <= r_d) begin
                        r_posa[r_sslot] <= r_pos;
                    end else begin
                        r_posa[r_cs] <= r_pos;
                        r_pos        <= su_parent;
                    end
                end
                S_CN_CHK: begin
                    r_ins <= 1'b0;
                    r_hit <= cn_hit;
                    if (cn_hit) begin
                        r_slot                     <= cn_idx[SLOT_W-1:0];
                        r_inh[cn_idx[SLOT_W-1:0]]  <= 1'b0;
                        r_fs[r_fcnt[SLOT_W-1:0]]   <= cn_idx[SLOT_W-1:0];
                        r_fcnt                     <= r_fcnt + 1'b1;
                        r_count                    <= r_count - 1'b1;
                        r_seq[cn_idx[SLOT_W-1:0]]  <= seq_val + 1'b1;
                        r_seqv[cn_idx[SLOT_W-1:0]] <= 1'b1;
                        r_pos                      <= r_posa[cn_idx[SLOT_W-1:0]];
                    end
                end
                S_RM_R1:  r_sslot <= heap_rd;
                S_RM_R2:  r_d <= dl_rd;
                S_SD_CHK: r_c <= sd_c[SLOT_W-1:0];
                S_SD_R1:  r_cs <= heap_rd;
                S_SD_R2:  r_rs <= heap_rd;
                S_SD_R3:  r_dcs <= dl_rd;
                S_SD_R4:  r_dcs <= dl_rd;
                S_SD_R5: begin
                    // right child wins only when strictly earlier
                    if (dl_rd < r_dcs) begin
                        r_c   <= c_next[SLOT_W-1:0];
                        r_cs  <= r_rs;
                        r_dcs <= dl_rd;
                    end
                end
                S_SD_CMP: begin
                    if (!(r_d <= r_dcs)) begin
                        r_posa[r_cs] <= r_pos;
                        r_pos        <= r_c;
                    end
                end
                S_AD_R1: r_slot <= heap_rd;
                S_AD_PUSH: begin
                    if (!r_pend_v || out_free) begin
                        r_pend_v                 <= 1'b1;
                        r_pend_slot              <= HSLOT_W'(r_slot) + 1'b1;
                        r_pend_seq               <= seq_val;
                        r_n                      <= r_n + 1'b1;
                        r_inh[r_slot]            <= 1'b0;
                        r_fs[r_fcnt[SLOT_W-1:0]] <= r_slot;
                        r_fcnt                   <= r_fcnt + 1'b1;
                        r_count                  <= r_count - 1'b1;
                        r_pos                    <= '0;
                    end
                end
                S_AD_END: if (out_free) r_pend_v <= 1'b0;
                S_RQ_FIN: r_slot <= r_nslot;
                default: ;
            endcase
        end
    end
endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for deadline_heap_timer_queue: directed and random
// commands against an in-bench heap predictor. Depends on hq_pkg, hq_in_if,
// hq_out_if and the RTL of the timer queue.
`default_nettype none

module tb;
    import hq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;  // no defined command, no result
    localparam int LIMIT = 4_000_000;
    localparam int SETTLE = 700;                   // cycles past last result

    typedef struct {
        t_kind             kind;
        logic [HSLOT_W-1:0] slot;
        logic [SEQ_W-1:0]   seq;
        logic               last;
    } t_result;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;

    hq_in_if  in_if();
    hq_out_if out_if();

    deadline_heap_timer_queue u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if), .o_out(out_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Heap predictor: own copy of time, heap, slots and free stack
    // ---------------------------------------------------------------
    logic [QUANT_W-1:0] cfg_quantum;
    logic [AMT_W-1:0]   cfg_max_delay;
    logic [TIME_W-1:0]  clock_ms;
    logic [SLOT_W-1:0]  heap_slot[SLOTS];
    int                 heap_len;
    logic [TIME_W-1:0]  slot_due[SLOTS];
    logic [SEQ_W-1:0]   slot_seq[SLOTS];
    int                 slot_pos[SLOTS];
    bit                 slot_live[SLOTS];
    int                 made_cnt;
    logic [SLOT_W-1:0]  free_lifo[SLOTS];
    int                 free_len;

    t_result pending_results[$];
    int      errors = 0;
    int      cycles = 0;
    int      snd_idle_pct = 0, rcv_idle_pct = 0;

    function automatic logic [TIME_W-1:0] quant();
        return (cfg_quantum == '0) ? 64'd1 : TIME_W'(cfg_quantum);
    endfunction

    function automatic void place(int p, int s);
        heap_slot[p] = s[SLOT_W-1:0];
        slot_pos[s]  = p;
    endfunction

    function automatic void climb(int p, int s);
        int par;
        while (p > 0) begin
            par = (p - 1) >> 1;
            if (slot_due[heap_slot[par]] <= slot_due[s]) break;
            place(p, heap_slot[par]);
            p = par;
        end
        place(p, s);
    endfunction

    function automatic int descend(int p, int s);
        int c;
        forever begin
            c = 2 * p + 1;
            if (c >= heap_len) break;
            if (c + 1 < heap_len && slot_due[heap_slot[c+1]] < slot_due[heap_slot[c]])
                c = c + 1;
            if (slot_due[s] <= slot_due[heap_slot[c]]) break;
            place(p, heap_slot[c]);
            p = c;
        end
        place(p, s);
        return p;
    endfunction

    // Pull heap entry p; its slot goes on the free stack, sequence untouched.
    function automatic void unlink(int p);
        int s, t, q;
        s = heap_slot[p];
        slot_live[s] = 1'b0;
        if (free_len < SLOTS) begin
            free_lifo[free_len] = s[SLOT_W-1:0];
            free_len++;
        end
        heap_len--;
        if (p != heap_len) begin
            t = heap_slot[heap_len];
            q = descend(p, t);
            climb(q, t);
        end
    endfunction

    function automatic bit drop_token(logic [HSLOT_W-1:0] hs, logic [SEQ_W-1:0] hq);
        int idx;
        if (hs == '0) return 1'b0;
        idx = int'(hs) - 1;
        if (idx >= made_cnt) return 1'b0;
        if (hq != slot_seq[idx] || !slot_live[idx]) return 1'b0;
        unlink(slot_pos[idx]);
        slot_seq[idx] += 1;
        return 1'b1;
    endfunction

    function automatic void push_result(t_kind k, logic [HSLOT_W-1:0] s, logic [SEQ_W-1:0] q);
        t_result r;
        r.kind = k; r.slot = s; r.seq = q; r.last = 1'b0;
        pending_results = {pending_results, r};
    endfunction

    function automatic void predict_command(logic [OP_W-1:0] op, logic [AMT_W-1:0] amt,
                                            logic [HSLOT_W-1:0] hs, logic [SEQ_W-1:0] hq);
        logic [TIME_W-1:0] delay, now_q;
        int s, n;
        n = 0;
        case (op)
            OP_REQUEST: begin
                delay = (amt > cfg_max_delay) ? TIME_W'(cfg_max_delay) : TIME_W'(amt);
                if (free_len > 0) begin
                    free_len--;
                    s = free_lifo[free_len];
                end else if (made_cnt < SLOTS) begin
                    s = made_cnt;
                    made_cnt++;
                end else begin
                    s = -1;
                end
                if (s < 0) begin
                    push_result(KIND_FULL, '0, '0);
                end else begin
                    slot_due[s] = (clock_ms + delay) / quant();
                    slot_seq[s] += 1;
                    slot_live[s] = 1'b1;
                    heap_len++;
                    climb(heap_len - 1, s);
                    void'(drop_token(hs, hq));
                    push_result(KIND_ISSUED, HSLOT_W'(s + 1), slot_seq[s]);
                end
                n = 1;
            end
            OP_CANCEL: begin
                if (drop_token(hs, hq)) push_result(KIND_CANCEL, hs, hq);
                else                    push_result(KIND_CANCEL, '0, '0);
                n = 1;
            end
            OP_ADVANCE: begin
                clock_ms += TIME_W'(amt);
                now_q = clock_ms / quant();
                while (n < SLOTS && heap_len > 0 && slot_due[heap_slot[0]] <= now_q) begin
                    s = heap_slot[0];
                    push_result(KIND_EXPIRED, HSLOT_W'(s + 1), slot_seq[s]);
                    n++;
                    unlink(0);
                end
                if (n == 0) begin
                    push_result(KIND_NONE, '0, '0);
                    n = 1;
                end
            end
            default: ;
        endcase
        if (n > 0) pending_results[$].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stall, field-by-field compare at the rising edge
    // ---------------------------------------------------------------
    task automatic report(string what);
        errors++;
        $display("mismatch @%0d: %s", cycles, what);
    endtask

    always @(negedge i_clk)
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);

    always @(posedge i_clk) begin
        t_result e;
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** deadline_heap_timer_queue: FAILED **");
            $finish;
        end else if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected transfer kind=%0d", out_if.kind));
            end else begin
                e = pending_results.pop_front();
                if (out_if.kind != e.kind)
                    report($sformatf("kind %0d, want %0d", out_if.kind, e.kind));
                if (out_if.token_slot != e.slot)
                    report($sformatf("slot %0d, want %0d", out_if.token_slot, e.slot));
                if (out_if.token_seq != e.seq)
                    report($sformatf("seq %h, want %h", out_if.token_seq, e.seq));
                if (out_if.last != e.last)
                    report($sformatf("last %0b, want %0b", out_if.last, e.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Command side. Tasks start and end at a falling edge; valid stays
    // high after a transfer until the next command or a pause lowers it.
    // ---------------------------------------------------------------
    task automatic send_cmd(logic [OP_W-1:0] op, logic [AMT_W-1:0] amt,
                            logic [HSLOT_W-1:0] hs, logic [SEQ_W-1:0] hq);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= op;
        in_if.amount_ms   <= amt;
        in_if.handle_slot <= hs;
        in_if.handle_seq  <= hq;
        do @(posedge i_clk); while (!in_if.ready);
        predict_command(op, amt, hs, hq);
        @(negedge i_clk);
    endtask

    // Stop sending, let every expected transfer arrive, then let the
    // sequencer finish any trailing removal.
    task automatic quiesce();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [PDATA_W-1:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_QUANTUM) cfg_quantum = val[QUANT_W-1:0];
        else                    cfg_max_delay = val[AMT_W-1:0];
    endtask

    // Token of a random live timer, or an empty handle when none is live.
    task automatic live_token(output logic [HSLOT_W-1:0] hs, output logic [SEQ_W-1:0] hq);
        int s;
        hs = '0; hq = '0;
        if (heap_len > 0) begin
            s = heap_slot[$urandom_range(heap_len - 1)];
            hs = HSLOT_W'(s + 1);
            hq = slot_seq[s];
        end
    endtask

    task automatic random_cmd();
        logic [HSLOT_W-1:0] hs;
        logic [SEQ_W-1:0]   hq;
        int pick;
        pick = $urandom_range(99);
        live_token(hs, hq);
        if (pick < 42) begin
            // request, sometimes replacing a live timer
            if ($urandom_range(9) < 6) begin hs = '0; hq = $urandom; end
            send_cmd(OP_REQUEST, ($urandom_range(3) == 0) ? AMT_W'($urandom)
                                 : AMT_W'($urandom_range(4000)), hs, hq);
        end else if (pick < 67) begin
            if ($urandom_range(9) < 3) begin
                hs = HSLOT_W'($urandom);
                hq = ($urandom_range(1) == 0) ? $urandom : hq;
            end
            send_cmd(OP_CANCEL, AMT_W'($urandom), hs, hq);
        end else if (pick < 94) begin
            send_cmd(OP_ADVANCE, ($urandom_range(5) == 0) ? AMT_W'($urandom)
                                 : AMT_W'($urandom_range(3000)), HSLOT_W'($urandom), $urandom);
        end else begin
            send_cmd(OP_UNDEF, AMT_W'($urandom), HSLOT_W'($urandom), $urandom);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_basic_ops();
        logic [HSLOT_W-1:0] hs;
        logic [SEQ_W-1:0]   hq;
        send_cmd(OP_ADVANCE, 16'd0, '0, '0);                  // empty heap: nothing due
        send_cmd(OP_REQUEST, 16'd0, '0, '0);                  // due at once
        send_cmd(OP_REQUEST, 16'hFFFF, '0, 32'hFFFF_FFFF);     // clamped to max delay
        send_cmd(OP_REQUEST, 16'd1000, '0, '0);
        live_token(hs, hq);
        send_cmd(OP_CANCEL, '0, hs, hq);                      // good token
        send_cmd(OP_CANCEL, '0, hs, hq);                      // already removed
        send_cmd(OP_CANCEL, '0, '0, '0);                      // empty handle
        send_cmd(OP_CANCEL, '0, 6'd1, ~SEQ_RESET);            // wrong sequence
        send_cmd(OP_CANCEL, '0, 6'd32, SEQ_RESET + 1);        // slot never made
        send_cmd(OP_CANCEL, '0, 6'h3F, 32'hFFFF_FFFF);        // out of range
        send_cmd(OP_UNDEF, 16'hFFFF, 6'h3F, 32'hFFFF_FFFF);   // ignored
        send_cmd(OP_ADVANCE, 16'd0, '0, '0);
        send_cmd(OP_ADVANCE, 16'hFFFF, '0, '0);
        quiesce();                                            // sender holds until drained
    endtask

    task automatic test_full_table();
        logic [HSLOT_W-1:0] hs;
        logic [SEQ_W-1:0]   hq;
        int s;
        write_reg(REG_QUANTUM, 32'd1000);
        write_reg(REG_MAXDELAY, 32'd65535);
        while (made_cnt < SLOTS || free_len > 0)
            send_cmd(OP_REQUEST, AMT_W'($urandom), '0, '0);
        send_cmd(OP_REQUEST, 16'd5, 6'd1, slot_seq[0]);       // full: old token kept
        live_token(hs, hq);
        send_cmd(OP_CANCEL, '0, hs, hq);
        // old token naming the timer it is about to create
        s = free_lifo[free_len - 1];
        send_cmd(OP_REQUEST, 16'd7, HSLOT_W'(s + 1), slot_seq[s] + 1);
        while (heap_len > 0) send_cmd(OP_ADVANCE, 16'hFFFF, '0, '0);
        quiesce();
    endtask

    task automatic test_config_corners();
        write_reg(REG_QUANTUM, 32'd0);                        // acts as one
        write_reg(REG_MAXDELAY, 32'd0);
        repeat (6) random_cmd();
        quiesce();
        write_reg(REG_QUANTUM, 32'h3FF);
        write_reg(REG_MAXDELAY, 32'd65535);
        repeat (6) random_cmd();
        quiesce();
        write_reg(REG_QUANTUM, 32'd1);
        write_reg(REG_MAXDELAY, 32'd300);
        repeat (6) random_cmd();
        quiesce();
    endtask

    task automatic test_random_traffic();
        int mode;
        for (mode = 0; mode < 3; mode++) begin
            snd_idle_pct = (mode == 0) ? 33 : (mode == 1) ? 59 : 0;
            rcv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 33 : 0;
            write_reg(REG_QUANTUM, 32'($urandom_range(1, 1000)));
            write_reg(REG_MAXDELAY, 32'($urandom_range(0, 65535)));
            repeat (25) random_cmd();
            quiesce();
        end
    endtask

    initial begin
        int i;
        in_if.valid = 1'b0; in_if.op = '0; in_if.amount_ms = '0;
        in_if.handle_slot = '0; in_if.handle_seq = '0;
        out_if.ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_rst_n = 1'b0;
        cfg_quantum = QUANT_RESET;
        cfg_max_delay = MAXD_RESET;
        clock_ms = '0; heap_len = 0; made_cnt = 0; free_len = 0;
        for (i = 0; i < SLOTS; i++) begin
            slot_seq[i] = SEQ_RESET;
            slot_live[i] = 1'b0;
            slot_pos[i] = 0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        snd_idle_pct = 33;
        rcv_idle_pct = 59;
        test_basic_ops();
        test_full_table();
        test_config_corners();
        test_random_traffic();

        quiesce();
        if (errors == 0)
            $display("** deadline_heap_timer_queue: PASSED **");
        else
            $display("** deadline_heap_timer_queue: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/hq_pkg.sv
rtl/hq_in_if.sv
rtl/hq_out_if.sv
rtl/hq_ram.sv
rtl/hq_div.sv
rtl/hq_cfg.sv
rtl/deadline_heap_timer_queue.sv
sim/tb.sv
